/* design/ptm_pkg.sv */
// Shared types and constants for the packet throughput meter.
package ptm_pkg;

  localparam int          FRAC_BITS_DEF      = 9;
  localparam int          WIDE_TIME_BITS_DEF = 27;
  localparam logic [31:0] US_PER_SEC         = 32'd1000000;
  localparam logic [7:0]  TPUS_RESET         = 8'd4;
  localparam logic        CMD_PACKET         = 1'b0;
  localparam logic        CMD_CLEAR          = 1'b1;

  typedef enum logic [2:0] {
    S_IDLE,
    S_GAP,
    S_LZ,
    S_WDIV,
    S_WQUO,
    S_NDIV,
    S_MUL,
    S_OUT
  } ptm_state_t;

  // request to the serial divider
  typedef struct packed {
    logic        start;
    logic [31:0] dividend;
    logic [31:0] divisor;
  } ptm_div_req_t;

endpackage

/* design/ptm_div.sv */
// Restoring divider, one quotient bit per cycle.
module ptm_div (
  input  logic                  clk,
  input  logic                  rst_n,
  input  ptm_pkg::ptm_div_req_t req,
  output logic                  done,
  output logic [31:0]           quotient
);
  import ptm_pkg::*;

  logic [31:0] rem_r, quo_r, dsr_r;
  logic [4:0]  cnt_r;
  logic        busy_r, done_r;
  logic [32:0] trial;
  logic        take;

  // trial subtract of the divisor from the partial remainder
  assign trial = {rem_r, quo_r[31]} - {1'b0, dsr_r};
  assign take  = !trial[32];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (req.start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + 5'd1;
        if (cnt_r == 5'd31) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      rem_r <= '0;
      quo_r <= req.dividend;
      dsr_r <= req.divisor;
    end else if (busy_r) begin
      rem_r <= take ? trial[31:0] : {rem_r[30:0], quo_r[31]};
      quo_r <= {quo_r[30:0], take};
    end
  end

  assign done     = done_r;
  assign quotient = quo_r;

endmodule

/* design/packet_throughput_meter_unit.sv */
// Top level of the packet throughput meter: sequencer, state and output word.
//
//  channel | ports                                         | dir
//  --------+-----------------------------------------------+----
//  in      | in_valid/in_ready, in_cmd, in_timestamp,       | in
//          | in_packet_bytes                               |
//  out     | out_valid/out_ready, out_throughput_int,       | out
//          | out_throughput_frac, out_frac_count,           |
//          | out_updated, out_divide_fault                 |
//  cfg     | cfg_valid/cfg_ready, cfg_data (ticks per us)   | in
//
// A clear or the first packet after a clear goes straight to the output
// state. A later packet runs the serial divider for the tick gap, then a
// leading-zero scan at one bit a cycle, then either two more divider passes
// (wide total; a zero whole-second quotient ends after the first) or one
// divider pass plus a shift-add multiply (narrow total). A zero time total
// ends straight after the gap pass. Synchronous active-low reset clears all
// measurement state and sets ticks per microsecond to 4. One word is worked
// on at a time; in_ready is high only when idle. The result sits in an
// output register, so the next word can start while a result waits; a
// finished result stalls only while the output register is still full.
module packet_throughput_meter_unit #(
  parameter int FRAC_BITS      = ptm_pkg::FRAC_BITS_DEF,
  parameter int WIDE_TIME_BITS = ptm_pkg::WIDE_TIME_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [0:0]  in_cmd,
  input  logic [31:0] in_timestamp,
  input  logic [10:0] in_packet_bytes,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [31:0] out_throughput_int,
  output logic [8:0]  out_throughput_frac,
  output logic [3:0]  out_frac_count,
  output logic        out_updated,
  output logic        out_divide_fault,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [7:0]  cfg_data
);
  import ptm_pkg::*;

  // largest leading-zero count that still means a wide time total
  localparam logic [4:0]  LZ_WIDE_MAX = 5'(32 - WIDE_TIME_BITS);
  localparam logic [31:0] NUM_BASE    = US_PER_SEC << FRAC_BITS;
  localparam logic [31:0] FRAC_MASK   = (32'd1 << FRAC_BITS) - 32'd1;

  ptm_state_t   state_r, state_nxt;
  ptm_div_req_t div_req;
  logic         div_done;
  logic [31:0]  div_q;

  // measurement state
  logic        first_pending_r;
  logic [31:0] last_stamp_r, elapsed_r, bit_total_r;
  logic [31:0] held_int_r;
  logic [8:0]  held_frac_r;
  logic [3:0]  held_cnt_r;
  logic        upd_r, fault_r;
  logic [7:0]  tpus_r;

  // working registers
  logic [10:0] bytes_r;
  logic [31:0] norm_r;
  logic [4:0]  lz_r;
  logic [31:0] acc_r, mcand_r, mplier_r;
  logic [4:0]  mcnt_r;

  // output word
  logic        out_valid_r;
  logic [31:0] out_int_r;
  logic [8:0]  out_frac_r;
  logic [3:0]  out_cnt_r;
  logic        out_upd_r, out_fault_r;

  logic        in_acc, out_load;
  logic [31:0] elapsed_sum, acc_sum, lz_mask, wide_q_shift;
  logic [7:0]  tpus_eff;
  logic        lz_found, wide_sel;

  assign in_acc      = in_valid && in_ready;
  assign tpus_eff    = (tpus_r == 8'd0) ? 8'd1 : tpus_r;
  assign elapsed_sum = elapsed_r + div_q;
  assign acc_sum     = acc_r + (mplier_r[0] ? mcand_r : 32'd0);
  assign lz_found    = norm_r[31];
  assign wide_sel    = (lz_r <= LZ_WIDE_MAX);
  // low lz bits of the quotient are the fraction; zero lz gives no fraction
  assign lz_mask      = 32'hFFFF_FFFF >> (6'd32 - {1'b0, lz_r});
  assign wide_q_shift = div_q >> lz_r;
  assign out_load     = !out_valid_r || out_ready;

  ptm_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .req      (div_req),
    .done     (div_done),
    .quotient (div_q)
  );

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          if (in_cmd == CMD_CLEAR || first_pending_r) state_nxt = S_OUT;
          else                                         state_nxt = S_GAP;
        end
      end
      S_GAP: begin
        if (div_done) state_nxt = (elapsed_sum == 32'd0) ? S_OUT : S_LZ;
      end
      S_LZ: begin
        if (lz_found) state_nxt = wide_sel ? S_WDIV : S_NDIV;
      end
      S_WDIV: begin
        if (div_done) state_nxt = (div_q == 32'd0) ? S_OUT : S_WQUO;
      end
      S_WQUO: begin
        if (div_done) state_nxt = S_OUT;
      end
      S_NDIV: begin
        if (div_done) state_nxt = S_MUL;
      end
      S_MUL: begin
        if (mcnt_r == 5'd31) state_nxt = S_OUT;
      end
      S_OUT: begin
        if (out_load) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // sequencer outputs: divider requests and handshakes
  always_comb begin
    div_req = '0;
    case (state_r)
      S_IDLE: begin
        if (in_acc && in_cmd == CMD_PACKET && !first_pending_r) begin
          div_req.start    = 1'b1;
          div_req.dividend = in_timestamp - last_stamp_r;
          div_req.divisor  = {24'd0, tpus_eff};
        end
      end
      S_LZ: begin
        if (lz_found) begin
          div_req.start = 1'b1;
          if (wide_sel) begin
            div_req.dividend = elapsed_r;
            div_req.divisor  = US_PER_SEC;
          end else begin
            div_req.dividend = NUM_BASE + {1'b0, elapsed_r[31:1]};
            div_req.divisor  = elapsed_r;
          end
        end
      end
      S_WDIV: begin
        if (div_done && div_q != 32'd0) begin
          div_req.start    = 1'b1;
          div_req.dividend = bit_total_r << lz_r;
          div_req.divisor  = div_q;
        end
      end
      default: div_req = '0;
    endcase
  end

  assign in_ready  = (state_r == S_IDLE);
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= S_IDLE;
    else        state_r <= state_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) tpus_r <= TPUS_RESET;
    else if (cfg_valid && cfg_ready) tpus_r <= cfg_data;
  end

  // measurement state and working registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      first_pending_r <= 1'b1;
      last_stamp_r    <= '0;
      elapsed_r       <= '0;
      bit_total_r     <= '0;
      held_int_r      <= '0;
      held_frac_r     <= '0;
      held_cnt_r      <= '0;
      upd_r           <= 1'b0;
      fault_r         <= 1'b0;
    end else begin
      case (state_r)
        S_IDLE: begin
          if (in_acc) begin
            upd_r   <= 1'b0;
            fault_r <= 1'b0;
            bytes_r <= in_packet_bytes;
            if (in_cmd == CMD_CLEAR) begin
              first_pending_r <= 1'b1;
              last_stamp_r    <= '0;
              elapsed_r       <= '0;
              bit_total_r     <= '0;
              held_int_r      <= '0;
              held_frac_r     <= '0;
              held_cnt_r      <= '0;
            end else begin
              last_stamp_r <= in_timestamp;
              if (first_pending_r) begin
                first_pending_r <= 1'b0;
                bit_total_r     <= bit_total_r + {18'd0, in_packet_bytes, 3'd0};
              end
            end
          end
        end
        S_GAP: begin
          if (div_done) begin
            elapsed_r <= elapsed_sum;
            norm_r    <= elapsed_sum;
            lz_r      <= '0;
            if (elapsed_sum == 32'd0) begin
              fault_r     <= 1'b1;
              bit_total_r <= bit_total_r + {18'd0, bytes_r, 3'd0};
            end
          end
        end
        S_LZ: begin
          if (!lz_found) begin
            norm_r <= {norm_r[30:0], 1'b0};
            lz_r   <= lz_r + 5'd1;
          end
        end
        S_WDIV: begin
          if (div_done && div_q == 32'd0) begin
            fault_r     <= 1'b1;
            bit_total_r <= bit_total_r + {18'd0, bytes_r, 3'd0};
          end
        end
        S_WQUO: begin
          if (div_done) begin
            held_int_r  <= wide_q_shift;
            held_frac_r <= div_q[8:0] & lz_mask[8:0];
            held_cnt_r  <= lz_r[3:0];
            upd_r       <= 1'b1;
            bit_total_r <= bit_total_r + {18'd0, bytes_r, 3'd0};
          end
        end
        S_NDIV: begin
          if (div_done) begin
            acc_r    <= '0;
            mcand_r  <= bit_total_r;
            mplier_r <= div_q;
            mcnt_r   <= '0;
          end
        end
        S_MUL: begin
          // shift-add multiply, low 32 bits of the product kept
          acc_r    <= acc_sum;
          mcand_r  <= {mcand_r[30:0], 1'b0};
          mplier_r <= {1'b0, mplier_r[31:1]};
          mcnt_r   <= mcnt_r + 5'd1;
          if (mcnt_r == 5'd31) begin
            held_int_r  <= acc_sum >> FRAC_BITS;
            held_frac_r <= acc_sum[8:0] & FRAC_MASK[8:0];
            held_cnt_r  <= 4'(FRAC_BITS);
            upd_r       <= 1'b1;
            bit_total_r <= bit_total_r + {18'd0, bytes_r, 3'd0};
          end
        end
        default: begin
        end
      endcase
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (state_r == S_OUT && out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == S_OUT && out_load) begin
      out_int_r   <= held_int_r;
      out_frac_r  <= held_frac_r;
      out_cnt_r   <= held_cnt_r;
      out_upd_r   <= upd_r;
      out_fault_r <= fault_r;
    end
  end

  assign out_valid           = out_valid_r;
  assign out_throughput_int  = out_int_r;
  assign out_throughput_frac = out_frac_r;
  assign out_frac_count      = out_cnt_r;
  assign out_updated         = out_upd_r;
  assign out_divide_fault    = out_fault_r;

endmodule

/* test/tb_top.sv */
// Testbench for the packet throughput meter: directed and random packet traffic checked by a predictor.
module tb_top;
  import ptm_pkg::*;

  // One result word as the block presents it.
  typedef struct packed {
    logic [31:0] tput_int;
    logic [8:0]  tput_frac;
    logic [3:0]  frac_n;
    logic        updated;
    logic        fault;
  } meter_reading_t;

  // Clock and reset: 8-unit period, reset held low at the start.
  logic clk   = 1'b0;
  logic rst_n = 1'b0;
  always #4 clk = ~clk;

  // Block inputs, all known from time zero.
  logic        in_valid        = 1'b0;
  logic [0:0]  in_cmd          = CMD_PACKET;
  logic [31:0] in_timestamp    = '0;
  logic [10:0] in_packet_bytes = '0;
  logic        out_ready       = 1'b0;
  logic        cfg_valid       = 1'b0;
  logic [7:0]  cfg_data        = '0;

  logic        in_ready;
  logic        out_valid;
  logic [31:0] out_throughput_int;
  logic [8:0]  out_throughput_frac;
  logic [3:0]  out_frac_count;
  logic        out_updated;
  logic        out_divide_fault;
  logic        cfg_ready;

  packet_throughput_meter_unit dut (
    .clk                 (clk),
    .rst_n               (rst_n),
    .in_valid            (in_valid),
    .in_ready            (in_ready),
    .in_cmd              (in_cmd),
    .in_timestamp        (in_timestamp),
    .in_packet_bytes     (in_packet_bytes),
    .out_valid           (out_valid),
    .out_ready           (out_ready),
    .out_throughput_int  (out_throughput_int),
    .out_throughput_frac (out_throughput_frac),
    .out_frac_count      (out_frac_count),
    .out_updated         (out_updated),
    .out_divide_fault    (out_divide_fault),
    .cfg_valid           (cfg_valid),
    .cfg_ready           (cfg_ready),
    .cfg_data            (cfg_data)
  );

  // Predictor state: a private copy of what the meter holds.
  logic [7:0]  tick_div   = TPUS_RESET;
  logic        first_pkt  = 1'b1;
  logic [31:0] prev_stamp = '0;
  logic [31:0] total_us   = '0;
  logic [31:0] total_bits = '0;
  logic [31:0] held_int   = '0;
  logic [31:0] held_frac  = '0;
  logic [31:0] held_count = '0;

  // Readings predicted at acceptance, oldest first.
  meter_reading_t expected_readings[$];

  int error_count = 0;
  int tx_idle_pct = 0;   // chance in 100 of the sender pausing before a word
  int rx_idle_pct = 0;   // chance in 100 of the receiver refusing a cycle
  logic rx_hold   = 1'b0;
  event rx_hold_ev;

  // One line per mismatch, and a count.
  task automatic report_mismatch(input string msg);
    error_count++;
    $display("tb_top: mismatch: %s", msg);
  endtask

  function automatic int unsigned count_leading_zeros(input logic [31:0] v);
    int unsigned n;
    n = 0;
    while (n < 32 && v[31 - n] == 1'b0)
      n++;
    return n;
  endfunction

  // Works out the reading for one accepted word and advances the state.
  task automatic predict_throughput(input logic cmd, input logic [31:0] stamp,
                                    input logic [10:0] nbytes,
                                    output meter_reading_t res);
    logic [31:0] divisor;
    logic [31:0] gap;
    logic [31:0] whole_s;
    logic [31:0] numer;
    logic [31:0] quo;
    int unsigned lz;
    res.updated = 1'b0;
    res.fault   = 1'b0;
    if (cmd == CMD_CLEAR) begin
      first_pkt  = 1'b1;
      prev_stamp = '0;
      total_us   = '0;
      total_bits = '0;
      held_int   = '0;
      held_frac  = '0;
      held_count = '0;
    end else begin
      if (first_pkt) begin
        // first packet after a clear records its stamp; no throughput is worked out
        prev_stamp = stamp;
        first_pkt  = 1'b0;
      end else begin
        divisor    = (tick_div == 8'd0) ? 32'd1 : {24'd0, tick_div};
        gap        = (stamp - prev_stamp) / divisor;
        prev_stamp = stamp;
        total_us   = total_us + gap;
        if (total_us == 32'd0) begin
          res.fault = 1'b1;
        end else begin
          lz = count_leading_zeros(total_us);
          if (32 - lz >= WIDE_TIME_BITS_DEF) begin
            // wide total: shift bits up by lz, divide by whole seconds
            whole_s = total_us / US_PER_SEC;
            if (whole_s == 32'd0) begin
              res.fault = 1'b1;
            end else begin
              quo         = (total_bits << lz) / whole_s;
              held_frac   = quo & ((32'd1 << lz) - 32'd1);
              held_int    = quo >> lz;
              held_count  = lz;
              res.updated = 1'b1;
            end
          end else begin
            // narrow total: rounded reciprocal times bits
            numer       = (US_PER_SEC << FRAC_BITS_DEF) + (total_us >> 1);
            quo         = total_bits * (numer / total_us);
            held_frac   = quo & ((32'd1 << FRAC_BITS_DEF) - 32'd1);
            held_int    = quo >> FRAC_BITS_DEF;
            held_count  = FRAC_BITS_DEF;
            res.updated = 1'b1;
          end
        end
      end
      // bits added only after the throughput used the earlier total
      total_bits = total_bits + {18'd0, nbytes, 3'b000};
    end
    res.tput_int  = held_int;
    res.tput_frac = held_frac[8:0];
    res.frac_n    = held_count[3:0];
  endtask

  // Offers one word, holding it until taken; prediction made on acceptance.
  task automatic send_word(input logic cmd, input logic [31:0] stamp,
                           input logic [10:0] nbytes);
    meter_reading_t res;
    if ($urandom_range(99) < tx_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
      while ($urandom_range(99) < tx_idle_pct)
        @(posedge clk);
    end
    in_valid        <= 1'b1;
    in_cmd          <= cmd;
    in_timestamp    <= stamp;
    in_packet_bytes <= nbytes;
    do
      @(posedge clk);
    while (!(in_valid && in_ready));
    predict_throughput(cmd, stamp, nbytes, res);
    expected_readings.push_back(res);
  endtask

  // Drops valid and waits until every reading is in, then settle more cycles.
  task automatic wait_drained(input int settle);
    in_valid <= 1'b0;
    @(posedge clk);
    while (expected_readings.size() != 0)
      @(posedge clk);
    repeat (settle) @(posedge clk);
  endtask

  // Writes ticks per microsecond; only called with the meter idle.
  task automatic write_tick_div(input logic [7:0] v);
    cfg_valid <= 1'b1;
    cfg_data  <= v;
    do
      @(posedge clk);
    while (!(cfg_valid && cfg_ready));
    tick_div = v;
    cfg_valid <= 1'b0;
  endtask

  // Gap in ticks: tiny ones give zero time totals, big ones the wide path.
  function automatic logic [31:0] pick_gap();
    int unsigned sel;
    int unsigned d;
    sel = $urandom_range(99);
    d   = (tick_div == 8'd0) ? 1 : tick_div;
    if (sel < 15)
      return $urandom_range(0, 2 * d);
    else if (sel < 55)
      return $urandom_range(1, 200000);
    else if (sel < 85)
      return $urandom_range(1, 32'h0FFF_FFFF);
    else
      return $urandom();
  endfunction

  function automatic logic [10:0] pick_bytes();
    int unsigned sel;
    sel = $urandom_range(99);
    if (sel < 5)
      return 11'd0;
    else if (sel < 10)
      return 11'h7FF;
    else
      return 11'($urandom_range(0, 2047));
  endfunction

  // Receiver: random ready, forced low during a hold-off; checks each word.
  always @(posedge clk) begin : rx_side
    meter_reading_t want;
    out_ready <= !rx_hold && ($urandom_range(99) >= rx_idle_pct);
    if (rst_n && out_valid && out_ready) begin
      if (expected_readings.size() == 0) begin
        report_mismatch("result word with nothing expected");
      end else begin
        want = expected_readings.pop_front();
        if (out_throughput_int !== want.tput_int)
          report_mismatch($sformatf("throughput_int got %0h expected %0h",
                                    out_throughput_int, want.tput_int));
        if (out_throughput_frac !== want.tput_frac)
          report_mismatch($sformatf("throughput_frac got %0h expected %0h",
                                    out_throughput_frac, want.tput_frac));
        if (out_frac_count !== want.frac_n)
          report_mismatch($sformatf("frac_count got %0d expected %0d",
                                    out_frac_count, want.frac_n));
        if (out_updated !== want.updated)
          report_mismatch($sformatf("updated got %0b expected %0b",
                                    out_updated, want.updated));
        if (out_divide_fault !== want.fault)
          report_mismatch($sformatf("divide_fault got %0b expected %0b",
                                    out_divide_fault, want.fault));
      end
    end
  end

  // Long receiver hold-off, counted here so the sender keeps pushing.
  initial begin
    forever begin
      @(rx_hold_ev);
      rx_hold <= 1'b1;
      repeat (700) @(posedge clk);
      rx_hold <= 1'b0;
    end
  end

  // Straight after reset, no clear and no register write: divisor of 4.
  task automatic test_reset_state();
    send_word(CMD_PACKET, 32'h0000_0010, 11'd100);
    send_word(CMD_PACKET, 32'h0000_0FB0, 11'd50);   // 4000 ticks = 1000 us
    wait_drained(4);
  endtask

  // Both throughput paths, zero totals and the wrap of the time total.
  task automatic test_throughput_paths();
    write_tick_div(8'd1);
    send_word(CMD_CLEAR, 32'hFFFF_FFFF, 11'h7FF);
    send_word(CMD_PACKET, 32'h0000_0000, 11'h7FF);  // first: stamp only
    send_word(CMD_PACKET, 32'h0000_0000, 11'd0);    // no time yet: fault
    send_word(CMD_PACKET, 32'h0000_03E8, 11'h7FF);  // narrow path
    send_word(CMD_PACKET, 32'h8000_03E8, 11'd1);    // total uses all 32 bits
    send_word(CMD_PACKET, 32'h0000_0000, 11'd500);  // total wraps to zero
    send_word(CMD_PACKET, 32'hFFFF_FFFF, 11'd0);    // largest total
    send_word(CMD_CLEAR, 32'h0000_0000, 11'd0);
    send_word(CMD_PACKET, 32'h1234_5678, 11'd100);
    send_word(CMD_PACKET, 32'h1634_5678, 11'd1);    // just wide: 27 bits
    send_word(CMD_CLEAR, 32'h0000_0000, 11'd0);
    send_word(CMD_PACKET, 32'h0000_0005, 11'd1);
    send_word(CMD_PACKET, 32'h0400_0004, 11'h7FF);  // widest narrow total
    send_word(CMD_PACKET, 32'h0400_0005, 11'd9);    // tips over to wide
    wait_drained(4);
  endtask

  // Divisor extremes: zero acts as one, 255 swallows short gaps.
  task automatic test_tick_extremes();
    write_tick_div(8'd0);
    send_word(CMD_CLEAR, 32'h0000_0000, 11'd0);
    send_word(CMD_PACKET, 32'd100, 11'd1);
    send_word(CMD_PACKET, 32'd101, 11'd7);          // one microsecond
    wait_drained(4);
    write_tick_div(8'd255);
    send_word(CMD_CLEAR, 32'h0000_0000, 11'd0);
    send_word(CMD_PACKET, 32'd0, 11'd10);
    send_word(CMD_PACKET, 32'd254, 11'd10);         // rounds to zero us
    send_word(CMD_PACKET, 32'd509, 11'd10);
    send_word(CMD_PACKET, 32'd508, 11'd10);         // stamp runs backwards
    wait_drained(4);
  endtask

  // Mostly clear-and-measure runs with random gaps; some runs skip the
  // clear, and some words are noise with arbitrary stamps.
  task automatic test_random_traffic(input int n_words);
    int sent;
    int run_len;
    logic [31:0] stamp;
    sent  = 0;
    stamp = $urandom();
    while (sent < n_words) begin
      if ($urandom_range(99) < 85) begin
        if ($urandom_range(99) < 80) begin
          send_word(CMD_CLEAR, $urandom(), pick_bytes());
          sent++;
        end
        run_len = $urandom_range(1, 12);
        repeat (run_len) begin
          stamp = stamp + pick_gap();
          send_word(CMD_PACKET, stamp, pick_bytes());
          sent++;
        end
      end else begin
        send_word(($urandom_range(9) == 0) ? CMD_CLEAR : CMD_PACKET,
                  $urandom(), pick_bytes());
        sent++;
      end
    end
    wait_drained(4);
  endtask

  // Receiver holds off long enough that a result waits in the output
  // register and the next word stalls the input.
  task automatic test_output_holdoff();
    logic [31:0] stamp;
    stamp = $urandom();
    -> rx_hold_ev;
    send_word(CMD_CLEAR, 32'h0000_0000, 11'd0);
    repeat (8) begin
      stamp = stamp + $urandom_range(1000, 500000);
      send_word(CMD_PACKET, stamp, pick_bytes());
    end
    wait_drained(4);
  endtask

  initial begin
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // sender idles 30 in 100, receiver 58
    tx_idle_pct = 30;
    rx_idle_pct = 58;
    test_reset_state();
    test_throughput_paths();
    test_tick_extremes();
    write_tick_div(8'($urandom_range(1, 255)));
    test_random_traffic(150);

    // the other way round
    tx_idle_pct = 58;
    rx_idle_pct = 30;
    write_tick_div(8'd1);
    test_random_traffic(150);

    // neither idles
    tx_idle_pct = 0;
    rx_idle_pct = 0;
    write_tick_div(8'd255);
    test_random_traffic(150);
    write_tick_div(TPUS_RESET);
    test_output_holdoff();

    wait_drained(150);
    if (expected_readings.size() != 0)
      report_mismatch("readings still expected at the end");
    if (error_count == 0)
      $display("tb_top: done, clean");
    else
      $display("tb_top: done, errors");
    $finish;
  end

  // Watchdog: far beyond the slowest correct run.
  initial begin
    #(8 * 1000000);
    $display("tb_top: done, errors");
    $finish;
  end

endmodule
